// ===== hdl/c8_pkg.sv =====
// Shared types, codes and tables for the CHIP-8 core.
// The sequencer state type, opcode codes, the font glyph table and the BCD split live here.
// Depends on nothing.
package c8_pkg;

    localparam int MEM_BYTES  = 4096;
    localparam int ADDR_W     = 12;
    localparam int SCR_W      = 64;
    localparam int SCR_H      = 32;
    localparam int ROW_W      = 5;
    localparam int FONT_BYTES = 80;
    localparam logic [11:0] PC_RESET = 12'h200;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_EXEC = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;
    localparam logic [1:0] KIND_ROW  = 2'd3;

    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JMP   = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SKEQ  = 4'h3;
    localparam logic [3:0] OP_SKNE  = 4'h4;
    localparam logic [3:0] OP_SKEQV = 4'h5;
    localparam logic [3:0] OP_SETV  = 4'h6;
    localparam logic [3:0] OP_ADDV  = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SKNEV = 4'h9;
    localparam logic [3:0] OP_SETI  = 4'hA;
    localparam logic [3:0] OP_JMPV  = 4'hB;
    localparam logic [3:0] OP_RAND  = 4'hC;
    localparam logic [3:0] OP_DRAW  = 4'hD;
    localparam logic [3:0] OP_KEY   = 4'hE;
    localparam logic [3:0] OP_MISC  = 4'hF;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_RSB = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] SYS_CLS = 8'hE0;
    localparam logic [7:0] SYS_RET = 8'hEE;

    localparam logic [7:0] KEY_DOWN = 8'h9E;
    localparam logic [7:0] KEY_UP   = 8'hA1;

    localparam logic [7:0] F_GET_DT = 8'h07;
    localparam logic [7:0] F_WAIT   = 8'h0A;
    localparam logic [7:0] F_SET_DT = 8'h15;
    localparam logic [7:0] F_SET_ST = 8'h18;
    localparam logic [7:0] F_ADD_I  = 8'h1E;
    localparam logic [7:0] F_FONT   = 8'h29;
    localparam logic [7:0] F_BCD    = 8'h33;
    localparam logic [7:0] F_STORE  = 8'h55;
    localparam logic [7:0] F_LOAD   = 8'h65;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_TICK, ST_ROW_RD, ST_ROW_WAIT,
        ST_F0, ST_F1, ST_F2, ST_F3, ST_EXEC, ST_WF, ST_BCD1, ST_BCD2,
        ST_ST_RD, ST_ST_WR, ST_LD_RD, ST_LD_WR, ST_DRW_RD, ST_DRW_WR, ST_DONE
    } c8_state_t;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // Reset contents of main memory: glyphs at the bottom, zero above.
    function automatic logic [7:0] font_byte(input logic [11:0] a);
        logic [7:0] b;
        b = 8'h00;
        if (a < 12'(FONT_BYTES)) begin
            b = FONT[a[6:0]];
        end
        return b;
    endfunction

    // Hundreds, tens and ones digits, packed high to low.
    function automatic logic [11:0] bcd_digits(input logic [7:0] v);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [7:0]  o;
        h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r = v - ({6'd0, h} * 8'd100);
        p = 15'(r) * 15'd205;
        t = p[14:11];
        o = r - ({4'd0, t} * 8'd10);
        return {2'b00, h, t, o[3:0]};
    endfunction

endpackage

// ===== hdl/c8_ram.sv =====
// Generic single-port RAM with registered read data.
// Width and depth are parameters; depends on nothing.
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/chip8_cpu_core.sv =====
// CHIP-8 processor core: sequencer around main memory, register file and frame buffer RAMs.
// Depends on c8_pkg and c8_ram.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser kind, s_tdata address..row
//  m_      | out | m_tvalid/m_tready  | m_tdata status, pc, row_pixels, sound_on
//
// Steps per request: load writes memory, tick counts timers down, row read reads the frame
// buffer, execute fetches both opcode bytes and VX/VY; an ALU op with flag adds a VF write,
// BCD two more writes, FX55/FX65 a read and a write per register, a sprite both per row and
// a VF write. Each RAM has one port, so each access is a step of its own. After reset a
// clearing pass fills main memory with the font and zeros; no request is taken meanwhile.
// A new request is taken only after the previous result has left the output register.
module chip8_cpu_core
    import c8_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[11:0], data[19:12], keys[35:20], random_byte[43:36], row[48:44], zero pad
    input  logic [55:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], pc[12:1], row_pixels[76:13], sound_on[77], zero pad
    output logic [79:0] m_tdata
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W  = $clog2(STACK_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

    c8_state_t state_reg, state_next;

    logic [1:0]  kind_reg;
    logic [11:0] ld_addr_reg;
    logic [7:0]  ld_data_reg;
    logic [15:0] keys_reg;
    logic [7:0]  rnd_reg;
    logic [4:0]  row_reg;

    logic [11:0] pc_reg, pc_next;
    logic [15:0] i_reg, i_next;
    logic [7:0]  dt_reg, dt_next;
    logic [7:0]  snd_reg, snd_next;
    logic        armed_reg, armed_next;
    logic [3:0]  kidx_reg, kidx_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [11:0] stack_reg [STACK_DEPTH];
    logic        push;

    logic [7:0]  hi_reg, hi_next, lo_reg, lo_next;
    logic [7:0]  vx_reg, vx_next, vy_reg, vy_next;
    logic        flag_reg, flag_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [11:0] bcd_reg, bcd_next;
    logic        status_reg, status_next;
    logic [63:0] pix_reg, pix_next;
    logic [11:0] clr_reg, clr_next;

    logic [15:0] vvalid_reg;
    logic [31:0] fvalid_reg;
    logic        fb_clear;
    logic        vrok_reg, frok_reg;

    logic        m_valid_reg;
    logic [79:0] m_data_reg;

    logic [11:0] mem_addr;
    logic        mem_we;
    logic [7:0]  mem_wdata, mem_rdata;
    logic [3:0]  v_addr;
    logic        v_we;
    logic [7:0]  v_wdata, v_rdata, vread;
    logic [4:0]  fb_addr;
    logic        fb_we;
    logic [63:0] fb_wdata, fb_rdata, frow;

    logic        s_accept;

    // decode
    logic [3:0]  op, x, n;
    logic [11:0] nnn, pc2, pc4;
    logic [DEPTH_W-1:0] dm1;
    logic        exec_err;
    c8_state_t   exec_goto;
    logic [7:0]  alu_res;
    logic [8:0]  sum9;
    logic        alu_flag;
    logic [3:0]  low_key;
    logic        any_key;
    logic [11:0] i_off;
    logic [4:0]  draw_row;
    logic [127:0] spr_dbl;
    logic [63:0] spr_mask;

    c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .aclk(aclk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
    );
    c8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
        .aclk(aclk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
    );
    c8_ram #(.WIDTH(SCR_W), .DEPTH(SCR_H)) u_fb (
        .aclk(aclk), .we(fb_we), .addr(fb_addr), .wdata(fb_wdata), .rdata(fb_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // unwritten entries read as zero
    assign vread = vrok_reg ? v_rdata : 8'h00;
    assign frow  = frok_reg ? fb_rdata : 64'h0;

    assign op  = hi_reg[7:4];
    assign x   = hi_reg[3:0];
    assign n   = lo_reg[3:0];
    assign nnn = {hi_reg[3:0], lo_reg};
    assign pc2 = pc_reg + 12'd2;
    assign pc4 = pc_reg + 12'd4;
    assign dm1 = depth_reg - DEPTH_W'(1);
    assign i_off    = i_reg[11:0] + {8'h00, cnt_reg};
    assign draw_row = vy_reg[4:0] + {1'b0, cnt_reg};
    assign spr_dbl  = {mem_rdata, 56'h0, mem_rdata, 56'h0} >> vx_reg[5:0];
    assign spr_mask = spr_dbl[63:0];
    assign sum9     = {1'b0, vx_reg} + {1'b0, vy_reg};

    always_comb begin
        low_key = 4'h0;
        any_key = 1'b0;
        for (int k = 15; k >= 0; k--) begin
            if (keys_reg[k]) begin
                low_key = 4'(k);
                any_key = 1'b1;
            end
        end
    end

    // instruction decode: error, ALU result and follow-up state
    always_comb begin
        exec_err  = 1'b0;
        exec_goto = ST_DONE;
        alu_res   = vy_reg;
        alu_flag  = 1'b0;
        case (n)
            ALU_OR:  alu_res = vx_reg | vy_reg;
            ALU_AND: alu_res = vx_reg & vy_reg;
            ALU_XOR: alu_res = vx_reg ^ vy_reg;
            ALU_ADD: begin
                alu_res  = sum9[7:0];
                alu_flag = sum9[8];
            end
            ALU_SUB: begin
                alu_res  = vx_reg - vy_reg;
                alu_flag = vx_reg >= vy_reg;
            end
            ALU_SHR: begin
                alu_res  = {1'b0, vy_reg[7:1]};
                alu_flag = vy_reg[0];
            end
            ALU_RSB: begin
                alu_res  = vy_reg - vx_reg;
                alu_flag = vy_reg >= vx_reg;
            end
            ALU_SHL: begin
                alu_res  = {vy_reg[6:0], 1'b0};
                alu_flag = vy_reg[7];
            end
            default: alu_res = vy_reg;
        endcase
        case (op)
            OP_SYS: begin
                if (x == 4'h0 && lo_reg == SYS_RET && depth_reg == '0) begin
                    exec_err = 1'b1;
                end
            end
            OP_CALL: begin
                if (depth_reg >= DEPTH_FULL) begin
                    exec_err = 1'b1;
                end
            end
            OP_ALU: begin
                if (n == ALU_OR || n == ALU_AND || n == ALU_XOR || n == ALU_ADD ||
                    n == ALU_SUB || n == ALU_SHR || n == ALU_RSB || n == ALU_SHL) begin
                    exec_goto = ST_WF;
                end else if (n != ALU_MOV) begin
                    exec_err = 1'b1;
                end
            end
            OP_DRAW: exec_goto = (n == 4'h0) ? ST_WF : ST_DRW_RD;
            OP_KEY: begin
                if ((lo_reg != KEY_DOWN && lo_reg != KEY_UP) || vx_reg > 8'h0F) begin
                    exec_err = 1'b1;
                end
            end
            OP_MISC: begin
                case (lo_reg)
                    F_GET_DT, F_WAIT, F_SET_DT, F_SET_ST, F_ADD_I, F_FONT: exec_goto = ST_DONE;
                    F_BCD:   exec_goto = ST_BCD1;
                    F_STORE: exec_goto = ST_ST_RD;
                    F_LOAD:  exec_goto = ST_LD_RD;
                    default: exec_err = 1'b1;
                endcase
            end
            default: exec_goto = ST_DONE;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == 12'(MEM_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        KIND_LOAD: state_next = ST_LOAD;
                        KIND_EXEC: state_next = ST_F0;
                        KIND_TICK: state_next = ST_TICK;
                        default:   state_next = ST_ROW_RD;
                    endcase
                end
            end
            ST_LOAD, ST_TICK, ST_ROW_WAIT, ST_WF, ST_BCD2: state_next = ST_DONE;
            ST_ROW_RD: state_next = ST_ROW_WAIT;
            ST_F0:     state_next = ST_F1;
            ST_F1:     state_next = ST_F2;
            ST_F2:     state_next = ST_F3;
            ST_F3:     state_next = ST_EXEC;
            ST_EXEC:   state_next = exec_err ? ST_DONE : exec_goto;
            ST_BCD1:   state_next = ST_BCD2;
            ST_ST_RD:  state_next = ST_ST_WR;
            ST_ST_WR:  state_next = (cnt_reg == x) ? ST_DONE : ST_ST_RD;
            ST_LD_RD:  state_next = ST_LD_WR;
            ST_LD_WR:  state_next = (cnt_reg == x) ? ST_DONE : ST_LD_RD;
            ST_DRW_RD: state_next = ST_DRW_WR;
            ST_DRW_WR: state_next = (cnt_reg == n - 4'h1) ? ST_WF : ST_DRW_RD;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        pc_next     = pc_reg;
        i_next      = i_reg;
        dt_next     = dt_reg;
        snd_next    = snd_reg;
        armed_next  = armed_reg;
        kidx_next   = kidx_reg;
        depth_next  = depth_reg;
        push        = 1'b0;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        flag_next   = flag_reg;
        cnt_next    = cnt_reg;
        bcd_next    = bcd_reg;
        status_next = status_reg;
        pix_next    = pix_reg;
        clr_next    = clr_reg;
        fb_clear    = 1'b0;
        mem_addr    = pc_reg;
        mem_we      = 1'b0;
        mem_wdata   = 8'h00;
        v_addr      = x;
        v_we        = 1'b0;
        v_wdata     = 8'h00;
        fb_addr     = row_reg;
        fb_we       = 1'b0;
        fb_wdata    = 64'h0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = font_byte(clr_reg);
                clr_next  = clr_reg + 12'd1;
            end
            ST_IDLE: begin
                status_next = 1'b0;
                pix_next    = 64'h0;
            end
            ST_LOAD: begin
                mem_we    = 1'b1;
                mem_addr  = ld_addr_reg;
                mem_wdata = ld_data_reg;
            end
            ST_TICK: begin
                if (dt_reg != 8'h00) begin
                    dt_next = dt_reg - 8'd1;
                end
                if (snd_reg != 8'h00) begin
                    snd_next = snd_reg - 8'd1;
                end
            end
            ST_ROW_RD:   fb_addr = row_reg;
            ST_ROW_WAIT: pix_next = frow;
            ST_F0:       mem_addr = pc_reg;
            ST_F1: begin
                hi_next  = mem_rdata;
                mem_addr = pc_reg + 12'd1;
                v_addr   = mem_rdata[3:0];
            end
            ST_F2: begin
                lo_next = mem_rdata;
                vx_next = vread;
                // BNNN needs V0 in place of VY
                v_addr  = (hi_reg[7:4] == OP_JMPV) ? 4'h0 : mem_rdata[7:4];
            end
            ST_F3: vy_next = vread;
            ST_EXEC: begin
                if (exec_err) begin
                    status_next = 1'b1;
                end else begin
                    pc_next = pc2;
                    case (op)
                        OP_SYS: begin
                            if (x == 4'h0 && lo_reg == SYS_RET) begin
                                depth_next = dm1;
                                pc_next    = stack_reg[dm1[SIDX_W-1:0]] + 12'd2;
                            end else if (x == 4'h0 && lo_reg == SYS_CLS) begin
                                fb_clear = 1'b1;
                            end
                        end
                        OP_JMP: pc_next = nnn;
                        OP_CALL: begin
                            push       = 1'b1;
                            depth_next = depth_reg + DEPTH_W'(1);
                            pc_next    = nnn;
                        end
                        OP_SKEQ:  pc_next = (vx_reg == lo_reg) ? pc4 : pc2;
                        OP_SKNE:  pc_next = (vx_reg != lo_reg) ? pc4 : pc2;
                        OP_SKEQV: pc_next = (vx_reg == vy_reg) ? pc4 : pc2;
                        OP_SKNEV: pc_next = (vx_reg != vy_reg) ? pc4 : pc2;
                        OP_SETV: begin
                            v_we    = 1'b1;
                            v_wdata = lo_reg;
                        end
                        OP_ADDV: begin
                            v_we    = 1'b1;
                            v_wdata = vx_reg + lo_reg;
                        end
                        OP_ALU: begin
                            v_we      = 1'b1;
                            v_wdata   = alu_res;
                            flag_next = alu_flag;
                        end
                        OP_SETI: i_next  = {4'h0, nnn};
                        OP_JMPV: pc_next = nnn + {4'h0, vy_reg};
                        OP_RAND: begin
                            v_we    = 1'b1;
                            v_wdata = rnd_reg & lo_reg;
                        end
                        OP_DRAW: begin
                            flag_next = 1'b0;
                            cnt_next  = 4'h0;
                        end
                        OP_KEY: begin
                            pc_next = (keys_reg[vx_reg[3:0]] == (lo_reg == KEY_DOWN)) ? pc4 : pc2;
                        end
                        default: begin
                            cnt_next = 4'h0;
                            case (lo_reg)
                                F_GET_DT: begin
                                    v_we    = 1'b1;
                                    v_wdata = dt_reg;
                                end
                                F_WAIT: begin
                                    if (!armed_reg) begin
                                        pc_next = pc_reg;
                                        if (any_key) begin
                                            armed_next = 1'b1;
                                            kidx_next  = low_key;
                                        end
                                    end else if (!keys_reg[kidx_reg]) begin
                                        armed_next = 1'b0;
                                        v_we       = 1'b1;
                                        v_wdata    = {4'h0, kidx_reg};
                                    end else begin
                                        pc_next = pc_reg;
                                    end
                                end
                                F_SET_DT: dt_next  = vx_reg;
                                F_SET_ST: snd_next = vx_reg;
                                F_ADD_I:  i_next   = i_reg + {8'h00, vx_reg};
                                F_FONT:   i_next   = 16'(vx_reg[3:0] * 7'd5);
                                F_BCD: begin
                                    bcd_next  = bcd_digits(vx_reg);
                                    mem_we    = 1'b1;
                                    mem_addr  = i_reg[11:0];
                                    mem_wdata = {4'h0, bcd_next[11:8]};
                                end
                                default: cnt_next = 4'h0;
                            endcase
                        end
                    endcase
                end
            end
            ST_WF: begin
                v_we    = 1'b1;
                v_addr  = 4'hF;
                v_wdata = {7'h00, flag_reg};
            end
            ST_BCD1: begin
                mem_we    = 1'b1;
                mem_addr  = i_reg[11:0] + 12'd1;
                mem_wdata = {4'h0, bcd_reg[7:4]};
            end
            ST_BCD2: begin
                mem_we    = 1'b1;
                mem_addr  = i_reg[11:0] + 12'd2;
                mem_wdata = {4'h0, bcd_reg[3:0]};
            end
            ST_ST_RD: v_addr = cnt_reg;
            ST_ST_WR: begin
                mem_we    = 1'b1;
                mem_addr  = i_off;
                mem_wdata = vread;
                cnt_next  = cnt_reg + 4'h1;
                if (cnt_reg == x) begin
                    i_next = i_reg + {12'h000, x} + 16'd1;
                end
            end
            ST_LD_RD: mem_addr = i_off;
            ST_LD_WR: begin
                v_we     = 1'b1;
                v_addr   = cnt_reg;
                v_wdata  = mem_rdata;
                cnt_next = cnt_reg + 4'h1;
                if (cnt_reg == x) begin
                    i_next = i_reg + {12'h000, x} + 16'd1;
                end
            end
            ST_DRW_RD: begin
                mem_addr = i_off;
                fb_addr  = draw_row;
            end
            ST_DRW_WR: begin
                fb_we     = 1'b1;
                fb_addr   = draw_row;
                fb_wdata  = frow ^ spr_mask;
                flag_next = flag_reg | (|(frow & spr_mask));
                cnt_next  = cnt_reg + 4'h1;
            end
            default: pc_next = pc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            pc_reg      <= PC_RESET;
            i_reg       <= 16'h0000;
            dt_reg      <= 8'h00;
            snd_reg     <= 8'h00;
            armed_reg   <= 1'b0;
            kidx_reg    <= 4'h0;
            depth_reg   <= '0;
            clr_reg     <= 12'h000;
            vvalid_reg  <= 16'h0000;
            fvalid_reg  <= 32'h0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            i_reg     <= i_next;
            dt_reg    <= dt_next;
            snd_reg   <= snd_next;
            armed_reg <= armed_next;
            kidx_reg  <= kidx_next;
            depth_reg <= depth_next;
            clr_reg   <= clr_next;
            if (v_we) begin
                vvalid_reg[v_addr] <= 1'b1;
            end
            if (fb_clear) begin
                fvalid_reg <= 32'h0;
            end else if (fb_we) begin
                fvalid_reg[fb_addr] <= 1'b1;
            end
            if (state_reg == ST_DONE) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg    <= s_tuser;
            ld_addr_reg <= s_tdata[11:0];
            ld_data_reg <= s_tdata[19:12];
            keys_reg    <= s_tdata[35:20];
            rnd_reg     <= s_tdata[43:36];
            row_reg     <= s_tdata[48:44];
        end
        if (push) begin
            stack_reg[depth_reg[SIDX_W-1:0]] <= pc_reg;
        end
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        flag_reg   <= flag_next;
        cnt_reg    <= cnt_next;
        bcd_reg    <= bcd_next;
        status_reg <= status_next;
        pix_reg    <= pix_next;
        vrok_reg   <= vvalid_reg[v_addr];
        frok_reg   <= fvalid_reg[fb_addr];
        // hold the result while the kind of the request is still on record
        if (state_reg == ST_DONE) begin
            m_data_reg <= {2'b00, snd_reg != 8'h00,
                           (kind_reg == KIND_ROW) ? pix_reg : 64'h0,
                           pc_reg, status_reg};
        end
    end

endmodule
